### hw/rtl/dda_pkg.sv
// Shared types, format constants and helpers for the double-word adder.
// Used by dda_fadd and double_double_adder_unit; no dependencies.
`default_nettype none
package dda_pkg;

  localparam int unsigned SIG_BITS = 64;
  localparam int unsigned EXP_BITS = 15;
  // carry bit, significand, guard, round, sticky
  localparam int unsigned EXT_W    = SIG_BITS + 4;
  localparam int unsigned SHW      = $clog2(EXT_W);
  localparam int unsigned EW       = EXP_BITS + 1;

  localparam int unsigned NSLOT    = 24;
  localparam int unsigned NLEVEL   = 13;
  localparam int unsigned NOP      = 4;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned ADD_LAT  = 3;

  localparam logic [EXP_BITS-1:0] EXP_ONES  = '1;
  localparam logic [SIG_BITS-1:0] INT_BIT   = {1'b1, {(SIG_BITS-1){1'b0}}};
  localparam logic [SIG_BITS-1:0] QUIET_BIT = {2'b01, {(SIG_BITS-2){1'b0}}};

  // value slots carried down the adder levels
  localparam logic [SLOT_W-1:0] S_AH = 5'd0,  S_BH = 5'd1,  S_AL = 5'd2,  S_BL = 5'd3;
  localparam logic [SLOT_W-1:0] S_SH = 5'd4,  S_SL = 5'd5,  S_VH = 5'd6,  S_VL = 5'd7;
  localparam logic [SLOT_W-1:0] S_TH = 5'd8,  S_UH = 5'd9,  S_TL = 5'd10, S_UL = 5'd11;
  localparam logic [SLOT_W-1:0] S_WH = 5'd12, S_WL = 5'd13, S_EH = 5'd14, S_EL = 5'd15;
  localparam logic [SLOT_W-1:0] S_Q1 = 5'd16, S_CH = 5'd17, S_Z1 = 5'd18, S_CL = 5'd19;
  localparam logic [SLOT_W-1:0] S_Q2 = 5'd20, S_RH = 5'd21, S_Z2 = 5'd22, S_RL = 5'd23;

  typedef struct packed {
    logic [15:0] se;
    logic [63:0] sig;
  } xf_t;

  typedef xf_t [NSLOT-1:0] bnd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
    logic              neg;
    logic [SLOT_W-1:0] dst;
  } op_t;

  function automatic op_t mk_op(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b, logic neg,
                                logic [SLOT_W-1:0] dst);
    op_t r;
    r.en  = 1'b1;
    r.a   = a;
    r.b   = b;
    r.neg = neg;
    r.dst = dst;
    return r;
  endfunction

  // adds of each level; a level has up to NOP independent adds
  function automatic op_t op_of(int lvl, int k);
    op_t r;
    r = '0;
    case (lvl * NOP + k)
      0:  r = mk_op(S_AH, S_BH, 1'b0, S_SH);
      1:  r = mk_op(S_AL, S_BL, 1'b0, S_SL);
      4:  r = mk_op(S_SH, S_AH, 1'b1, S_VH);
      5:  r = mk_op(S_SL, S_AL, 1'b1, S_VL);
      8:  r = mk_op(S_SH, S_VH, 1'b1, S_TH);
      9:  r = mk_op(S_BH, S_VH, 1'b1, S_UH);
      10: r = mk_op(S_SL, S_VL, 1'b1, S_TL);
      11: r = mk_op(S_BL, S_VL, 1'b1, S_UL);
      12: r = mk_op(S_AH, S_TH, 1'b1, S_WH);
      13: r = mk_op(S_AL, S_TL, 1'b1, S_WL);
      16: r = mk_op(S_WH, S_UH, 1'b0, S_EH);
      17: r = mk_op(S_WL, S_UL, 1'b0, S_EL);
      20: r = mk_op(S_EH, S_SL, 1'b0, S_Q1);
      24: r = mk_op(S_SH, S_Q1, 1'b0, S_CH);
      28: r = mk_op(S_CH, S_SH, 1'b1, S_Z1);
      32: r = mk_op(S_Q1, S_Z1, 1'b1, S_CL);
      36: r = mk_op(S_EL, S_CL, 1'b0, S_Q2);
      40: r = mk_op(S_CH, S_Q2, 1'b0, S_RH);
      44: r = mk_op(S_RH, S_CH, 1'b1, S_Z2);
      48: r = mk_op(S_Q2, S_Z2, 1'b1, S_RL);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic xf_t pack_xf(logic s, logic [EXP_BITS-1:0] e, logic [SIG_BITS-1:0] m);
    xf_t r;
    r = '0;
    r.se[15] = s;
    r.se[EXP_BITS-1:0] = e;
    r.sig[SIG_BITS-1:0] = m;
    return r;
  endfunction

  // leading zeros of the word below the carry bit
  function automatic logic [SHW-1:0] lzc(logic [EXT_W-2:0] v);
    logic [SHW-1:0] n;
    n = SHW'(EXT_W - 1);
    for (int i = 0; i < EXT_W - 1; i++) begin
      if (v[i]) n = SHW'(EXT_W - 2 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/double_double_adder_unit.sv
// Top level of the double-word adder: thirteen levels of pipelined adders.
// Depends on dda_pkg and dda_fadd.
//
// Usage:
//   An operand transfer happens at a rising edge with start high; busy is
//   always low, so a new pair of double-word operands may enter each cycle.
//   The sum (high and low words) appears on the sum ports for one cycle
//   with done_o high, after 13 dependent levels of extended-precision
//   adds, each a 3-stage dda_fadd. Throughput is one item per cycle;
//   independent adds of a level run side by side.
//   Operands and intermediates needed by later levels ride along in a
//   delay line matching each level.
//   Reset clears all valid bits; no result is produced until a transfer.
//   The receiver cannot stall; results are presented once and not held.
`default_nettype none
module double_double_adder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] a_high_sign_exp_i,
  input  wire logic [63:0] a_high_significand_i,
  input  wire logic [15:0] a_low_sign_exp_i,
  input  wire logic [63:0] a_low_significand_i,
  input  wire logic [15:0] b_high_sign_exp_i,
  input  wire logic [63:0] b_high_significand_i,
  input  wire logic [15:0] b_low_sign_exp_i,
  input  wire logic [63:0] b_low_significand_i,
  output logic             done_o,
  output logic [15:0]      sum_high_sign_exp_o,
  output logic [63:0]      sum_high_significand_o,
  output logic [15:0]      sum_low_sign_exp_o,
  output logic [63:0]      sum_low_significand_o
);
  import dda_pkg::*;

  bnd_t              lvl_bnd [NLEVEL+1];
  bnd_t              in_bnd;
  logic [NLEVEL:0]   lvl_vld;

  assign busy = 1'b0;

  always_comb begin
    in_bnd       = '0;
    in_bnd[S_AH] = '{se: a_high_sign_exp_i, sig: a_high_significand_i};
    in_bnd[S_BH] = '{se: b_high_sign_exp_i, sig: b_high_significand_i};
    in_bnd[S_AL] = '{se: a_low_sign_exp_i,  sig: a_low_significand_i};
    in_bnd[S_BL] = '{se: b_low_sign_exp_i,  sig: b_low_significand_i};
  end
  assign lvl_bnd[0] = in_bnd;
  assign lvl_vld[0] = start & ~busy;

  for (genvar l = 0; l < NLEVEL; l++) begin : g_lvl
    bnd_t dly_q [ADD_LAT];
    xf_t  res [NOP];
    bnd_t nxt;

    always_ff @(posedge clk_i) begin
      dly_q[0] <= lvl_bnd[l];
      for (int i = 1; i < ADD_LAT; i++) dly_q[i] <= dly_q[i-1];
    end

    for (genvar k = 0; k < NOP; k++) begin : g_op
      localparam op_t OP = op_of(l, k);
      if (OP.en) begin : g_add
        if (k == 0) begin : g_lead
          dda_fadd u_add (
            .clk_i   (clk_i),
            .rst_ni  (rst_ni),
            .valid_i (lvl_vld[l]),
            .a_i     (lvl_bnd[l][OP.a]),
            .b_i     (lvl_bnd[l][OP.b]),
            .neg_i   (OP.neg),
            .valid_o (lvl_vld[l+1]),
            .sum_o   (res[k])
          );
        end else begin : g_side
          dda_fadd u_add (
            .clk_i   (clk_i),
            .rst_ni  (rst_ni),
            .valid_i (lvl_vld[l]),
            .a_i     (lvl_bnd[l][OP.a]),
            .b_i     (lvl_bnd[l][OP.b]),
            .neg_i   (OP.neg),
            .valid_o (),
            .sum_o   (res[k])
          );
        end
      end else begin : g_none
        assign res[k] = '0;
      end
    end

    always_comb begin
      op_t op;
      nxt = dly_q[ADD_LAT-1];
      for (int k = 0; k < NOP; k++) begin
        op = op_of(l, k);
        if (op.en) nxt[op.dst] = res[k];
      end
    end
    assign lvl_bnd[l+1] = nxt;
  end

  assign done_o                 = lvl_vld[NLEVEL];
  assign sum_high_sign_exp_o    = lvl_bnd[NLEVEL][S_RH].se;
  assign sum_high_significand_o = lvl_bnd[NLEVEL][S_RH].sig;
  assign sum_low_sign_exp_o     = lvl_bnd[NLEVEL][S_RL].se;
  assign sum_low_significand_o  = lvl_bnd[NLEVEL][S_RL].sig;

endmodule
`default_nettype wire

### hw/rtl/dda_fadd.sv
// Three-stage pipelined extended-precision adder, round to nearest even.
// Stages: unpack/align, add/count, normalize/round. Uses dda_pkg.
`default_nettype none
module dda_fadd (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire dda_pkg::xf_t  a_i,
  input  wire dda_pkg::xf_t  b_i,
  input  wire logic          neg_i,
  output logic               valid_o,
  output dda_pkg::xf_t       sum_o
);
  import dda_pkg::*;

  // ---- stage A: classify, order by magnitude, align
  logic [EXP_BITS-1:0] ex, ey, qx, qy, qbig, qsml, dexp;
  logic [SIG_BITS-1:0] mx, my, mbig, msml, wm;
  logic                sx, sy, ix, iy, bad_x, bad_y, nan_x, nan_y, inf_x, inf_y;
  logic                zero_x, zero_y, x_ge, win_y, ws;
  logic [SHW-1:0]      sh;
  logic [EXT_W-1:0]    ext_s, al_s, lostm;
  logic                spec_d;
  xf_t                 spec_res_d;
  xf_t                 dnan;

  assign ex = a_i.se[EXP_BITS-1:0];
  assign ey = b_i.se[EXP_BITS-1:0];
  assign mx = a_i.sig[SIG_BITS-1:0];
  assign my = b_i.sig[SIG_BITS-1:0];
  assign sx = a_i.se[15];
  assign sy = b_i.se[15] ^ neg_i;
  assign ix = mx[SIG_BITS-1];
  assign iy = my[SIG_BITS-1];

  // unnormal, and integer bit clear at the top exponent
  assign bad_x  = (ex != '0) && !ix;
  assign bad_y  = (ey != '0) && !iy;
  assign nan_x  = (ex == EXP_ONES) && ix && (|mx[SIG_BITS-2:0]);
  assign nan_y  = (ey == EXP_ONES) && iy && (|my[SIG_BITS-2:0]);
  assign inf_x  = (ex == EXP_ONES) && ix && !(|mx[SIG_BITS-2:0]);
  assign inf_y  = (ey == EXP_ONES) && iy && !(|my[SIG_BITS-2:0]);
  assign zero_x = (ex == '0) && (mx == '0);
  assign zero_y = (ey == '0) && (my == '0);
  assign qx     = (ex == '0) ? EXP_BITS'(1) : ex;
  assign qy     = (ey == '0) ? EXP_BITS'(1) : ey;
  assign dnan   = pack_xf(1'b1, EXP_ONES, INT_BIT | QUIET_BIT);

  // NaN choice ignores the negation of the second operand
  assign win_y = !nan_x ? 1'b1 :
                 !nan_y ? 1'b0 :
                 (mx[SIG_BITS-2] != my[SIG_BITS-2]) ? my[SIG_BITS-2] : (my > mx);
  assign ws    = win_y ? b_i.se[15] : sx;
  assign wm    = win_y ? my : mx;

  always_comb begin
    spec_d     = 1'b1;
    spec_res_d = dnan;
    if (bad_x || bad_y) begin
      spec_res_d = dnan;
    end else if (nan_x || nan_y) begin
      spec_res_d = pack_xf(ws, EXP_ONES, wm | QUIET_BIT);
    end else if (inf_x || inf_y) begin
      if (inf_x && inf_y && (sx != sy)) spec_res_d = dnan;
      else spec_res_d = pack_xf(inf_x ? sx : sy, EXP_ONES, INT_BIT);
    end else if (zero_x && zero_y) begin
      spec_res_d = pack_xf(sx & sy, '0, '0);
    end else begin
      spec_d = 1'b0;
    end
  end

  assign x_ge  = {qx, mx} >= {qy, my};
  assign qbig  = x_ge ? qx : qy;
  assign qsml  = x_ge ? qy : qx;
  assign mbig  = x_ge ? mx : my;
  assign msml  = x_ge ? my : mx;
  assign dexp  = qbig - qsml;
  assign sh    = (dexp >= EXP_BITS'(EXT_W - 1)) ? SHW'(EXT_W - 1) : dexp[SHW-1:0];
  assign ext_s = {1'b0, msml, 3'b000};
  assign lostm = ~({EXT_W{1'b1}} << sh);
  assign al_s  = (ext_s >> sh) | EXT_W'(|(ext_s & lostm));

  logic                a_vld_q, a_spec_q, a_sgn_q, a_sub_q;
  xf_t                 a_res_q;
  logic [EW-1:0]       a_exp_q;
  logic [EXT_W-1:0]    a_xe_q, a_ye_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else a_vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    a_spec_q <= spec_d;
    a_res_q  <= spec_res_d;
    a_sgn_q  <= x_ge ? sx : sy;
    a_sub_q  <= sx ^ sy;
    a_exp_q  <= EW'(qbig);
    a_xe_q   <= {1'b0, mbig, 3'b000};
    a_ye_q   <= al_s;
  end

  // ---- stage B: add or subtract, fold carry, count leading zeros
  logic [EXT_W-1:0] raw, fix;
  logic [EW-1:0]    exp_b, lim;
  logic [SHW-1:0]   lz, shl_d;

  assign raw   = a_sub_q ? (a_xe_q - a_ye_q) : (a_xe_q + a_ye_q);
  assign fix   = raw[EXT_W-1] ? ((raw >> 1) | EXT_W'(raw[0])) : raw;
  assign exp_b = raw[EXT_W-1] ? (a_exp_q + EW'(1)) : a_exp_q;
  assign lz    = lzc(fix[EXT_W-2:0]);
  // left shift stops at the smallest normal exponent
  assign lim   = exp_b - EW'(1);
  assign shl_d = (EW'(lz) < lim) ? lz : lim[SHW-1:0];

  logic                b_vld_q, b_spec_q, b_sgn_q;
  xf_t                 b_res_q;
  logic [EW-1:0]       b_exp_q;
  logic [EXT_W-1:0]    b_r_q;
  logic [SHW-1:0]      b_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    b_spec_q <= a_spec_q;
    b_res_q  <= a_res_q;
    b_sgn_q  <= (fix == '0) ? 1'b0 : a_sgn_q;  // exact cancellation gives +0
    b_exp_q  <= exp_b;
    b_r_q    <= fix;
    b_sh_q   <= shl_d;
  end

  // ---- stage C: normalize, round, pack
  logic [EXT_W-1:0]    rn;
  logic [EW-1:0]       exp_n, exp_f;
  logic [SIG_BITS-1:0] kept, fin_m;
  logic [SIG_BITS:0]   rsum;
  logic                g, st, inc;
  xf_t                 fin;

  assign rn    = b_r_q << b_sh_q;
  assign exp_n = b_exp_q - EW'(b_sh_q);
  assign kept  = rn[SIG_BITS+2:3];
  assign g     = rn[2];
  assign st    = |rn[1:0];
  assign inc   = g & (st | kept[0]);
  assign rsum  = {1'b0, kept} + (SIG_BITS+1)'(inc);
  assign fin_m = rsum[SIG_BITS] ? INT_BIT : rsum[SIG_BITS-1:0];
  assign exp_f = rsum[SIG_BITS] ? (exp_n + EW'(1)) : exp_n;

  always_comb begin
    if (b_spec_q) fin = b_res_q;
    else if (exp_f >= EW'(EXP_ONES)) fin = pack_xf(b_sgn_q, EXP_ONES, INT_BIT);
    else fin = pack_xf(b_sgn_q, fin_m[SIG_BITS-1] ? exp_f[EXP_BITS-1:0] : '0, fin_m);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    sum_o <= fin;
  end

endmodule
`default_nettype wire

### tb/tb_double_double_adder_unit.sv
// Self-checking testbench for double_double_adder_unit: directed table plus random
// double-word operands, checked against an exact integer model of x87 extended adds.
// Depends on dda_pkg (xf_t, INT_BIT, QUIET_BIT, EXP_ONES) and the unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_double_double_adder_unit;
  import dda_pkg::*;

  localparam int BIAS_V  = 16383;
  localparam int EMIN_V  = 1 - BIAS_V;
  localparam int EMAX_V  = 32766 - BIAS_V;
  localparam int TOP     = 125;
  localparam int WD_LIMIT = 2000;

  typedef enum logic [2:0] {CL_ZERO, CL_FIN, CL_INF, CL_NAN, CL_BAD} fclass_e;

  typedef struct {
    fclass_e      cls;
    bit           sgn;
    int           ex;
    logic [127:0] mag;
    logic [63:0]  m;
  } fparts_t;

  typedef struct {
    xf_t ah, al, bh, bl;
  } dd_operands_t;

  typedef struct {
    xf_t hi, lo;
  } dd_sum_t;

  typedef struct {
    dd_operands_t op;
    bit           typed;
    dd_sum_t      want;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] a_high_sign_exp_i = '0;
  logic [63:0] a_high_significand_i = '0;
  logic [15:0] a_low_sign_exp_i = '0;
  logic [63:0] a_low_significand_i = '0;
  logic [15:0] b_high_sign_exp_i = '0;
  logic [63:0] b_high_significand_i = '0;
  logic [15:0] b_low_sign_exp_i = '0;
  logic [63:0] b_low_significand_i = '0;
  logic        done_o;
  logic [15:0] sum_high_sign_exp_o;
  logic [63:0] sum_high_significand_o;
  logic [15:0] sum_low_sign_exp_o;
  logic [63:0] sum_low_significand_o;

  double_double_adder_unit uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  dd_sum_t    expected_sums[$];
  table_row_t directed_rows[$];
  int         mismatches = 0;
  int         idle_cycles = 0;

  // ---------------- extended-precision add, exact integer arithmetic
  function automatic int msb_pos(logic [127:0] v);
    for (int k = 127; k > 0; k--) if (v[k]) return k;
    return 0;
  endfunction

  function automatic xf_t mk_xf(bit s, logic [14:0] e, logic [63:0] sig);
    xf_t r;
    r.se  = {s, e};
    r.sig = sig;
    return r;
  endfunction

  function automatic xf_t default_nan();
    return mk_xf(1'b1, EXP_ONES, INT_BIT | QUIET_BIT);
  endfunction

  function automatic fparts_t split_xf(xf_t v);
    fparts_t u;
    int unsigned e;
    int L;
    e = v.se[14:0];
    u.sgn = v.se[15];
    u.m = v.sig;
    u.ex = 0;
    u.mag = '0;
    u.cls = CL_FIN;
    if (e == 32767) begin
      if (!v.sig[63]) u.cls = CL_BAD;
      else u.cls = (v.sig[62:0] != 0) ? CL_NAN : CL_INF;
      return u;
    end
    if (e == 0 && v.sig == 0) begin
      u.cls = CL_ZERO;
      return u;
    end
    if (e != 0 && !v.sig[63]) begin
      u.cls = CL_BAD;
      return u;
    end
    L = msb_pos({64'b0, v.sig});
    u.mag = {64'b0, v.sig} << (TOP - L);
    // pseudo-denormal takes the value of exponent 1
    u.ex = ((e == 0) ? EMIN_V : int'(e) - BIAS_V) - 63 + L;
    return u;
  endfunction

  function automatic logic [127:0] shr_sticky(logic [127:0] x, int n);
    logic [127:0] r;
    if (n >= 127) return {127'b0, |x};
    r = x >> n;
    if ((x & ((128'b1 << n) - 1)) != 0) r[0] = 1'b1;
    return r;
  endfunction

  function automatic xf_t round_pack(bit sgn, int ex, logic [127:0] x);
    int extra;
    int sh;
    logic [127:0] shifted;
    logic [63:0] kept;
    extra = (ex < EMIN_V) ? EMIN_V - ex : 0;
    if (extra > 200) extra = 200;
    sh = 62 + extra;
    if (sh >= 127) return mk_xf(sgn, '0, '0);
    shifted = x >> sh;
    kept = shifted[63:0];
    if (x[sh-1] && (((x & ((128'b1 << (sh - 1)) - 1)) != 0) || kept[0])) kept = kept + 1;
    if (extra > 0) return mk_xf(sgn, kept[63] ? 15'd1 : 15'd0, kept);
    if (kept == 0) begin
      kept = INT_BIT;
      ex++;
    end
    if (ex > EMAX_V) return mk_xf(sgn, EXP_ONES, INT_BIT);
    return mk_xf(sgn, 15'(ex + BIAS_V), kept);
  endfunction

  function automatic xf_t pick_nan(fparts_t x, fparts_t y);
    fparts_t w;
    if (x.cls != CL_NAN) w = y;
    else if (y.cls != CL_NAN) w = x;
    else if (x.m[62] != y.m[62]) w = x.m[62] ? x : y;
    else w = (y.m > x.m) ? y : x;
    return mk_xf(w.sgn, EXP_ONES, w.m | QUIET_BIT);
  endfunction

  function automatic xf_t ext_add(xf_t a, xf_t b, bit negb);
    fparts_t x, y, t;
    logic [127:0] bs, r;
    int ex, L;
    x = split_xf(a);
    y = split_xf(b);
    if (x.cls == CL_BAD || y.cls == CL_BAD) return default_nan();
    if (x.cls == CL_NAN || y.cls == CL_NAN) return pick_nan(x, y);
    y.sgn ^= negb;
    if (x.cls == CL_INF || y.cls == CL_INF) begin
      if (x.cls == CL_INF && y.cls == CL_INF && x.sgn != y.sgn) return default_nan();
      return mk_xf(x.cls == CL_INF ? x.sgn : y.sgn, EXP_ONES, INT_BIT);
    end
    if (x.cls == CL_ZERO && y.cls == CL_ZERO) return mk_xf(x.sgn & y.sgn, '0, '0);
    if (y.cls == CL_ZERO) return round_pack(x.sgn, x.ex, x.mag);
    if (x.cls == CL_ZERO) return round_pack(y.sgn, y.ex, y.mag);
    if (x.ex < y.ex) begin
      t = x;
      x = y;
      y = t;
    end
    bs = shr_sticky(y.mag, x.ex - y.ex);
    ex = x.ex;
    if (x.sgn == y.sgn) begin
      r = x.mag + bs;
      if (r[TOP+1]) begin
        r = shr_sticky(r, 1);
        ex++;
      end
      return round_pack(x.sgn, ex, r);
    end
    if (x.mag == bs) return mk_xf(1'b0, '0, '0);
    if (x.mag > bs) r = x.mag - bs;
    else r = bs - x.mag;
    L = msb_pos(r);
    r = r << (TOP - L);
    ex -= TOP - L;
    return round_pack((x.mag > bs) ? x.sgn : y.sgn, ex, r);
  endfunction

  function automatic dd_sum_t accurate_dd_sum(dd_operands_t op);
    xf_t sh, vh, eh, sl, vl, el, q1, ch, cl, q2;
    dd_sum_t r;
    sh = ext_add(op.ah, op.bh, 1'b0);
    vh = ext_add(sh, op.ah, 1'b1);
    eh = ext_add(ext_add(op.ah, ext_add(sh, vh, 1'b1), 1'b1), ext_add(op.bh, vh, 1'b1), 1'b0);
    sl = ext_add(op.al, op.bl, 1'b0);
    vl = ext_add(sl, op.al, 1'b1);
    el = ext_add(ext_add(op.al, ext_add(sl, vl, 1'b1), 1'b1), ext_add(op.bl, vl, 1'b1), 1'b0);
    q1 = ext_add(eh, sl, 1'b0);
    ch = ext_add(sh, q1, 1'b0);
    cl = ext_add(q1, ext_add(ch, sh, 1'b1), 1'b1);
    q2 = ext_add(el, cl, 1'b0);
    r.hi = ext_add(ch, q2, 1'b0);
    r.lo = ext_add(q2, ext_add(r.hi, ch, 1'b1), 1'b1);
    return r;
  endfunction

  // ---------------- stimulus generation
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int clamp_exp(int e);
    return (e < 1) ? 1 : (e > 32766) ? 32766 : e;
  endfunction

  function automatic xf_t rand_word(int center);
    bit s;
    logic [63:0] sig;
    s = 1'($urandom_range(0, 1));
    sig = rand64();
    case ($urandom_range(0, 39))
      0: return mk_xf(s, '0, '0);
      1: return mk_xf(s, EXP_ONES, INT_BIT);
      2: return mk_xf(s, EXP_ONES, INT_BIT | (sig[62:0] == 0 ? 64'd1 : {1'b0, sig[62:0]}));
      3: return mk_xf(s, 15'($urandom_range(1, 32767)), {1'b0, sig[62:0]});
      4: return mk_xf(s, '0, sig);  // subnormal or pseudo-denormal
      5: return mk_xf(s, 15'($urandom), sig);
      default: return mk_xf(s, 15'(clamp_exp(center + $urandom_range(0, 6) - 3)),
                            INT_BIT | sig);
    endcase
  endfunction

  function automatic dd_operands_t rand_operands();
    dd_operands_t op;
    int hc;
    if ($urandom_range(0, 19) == 0) begin
      op.ah = {16'($urandom_range(0, 65535)), rand64()};
      op.al = {16'($urandom_range(0, 65535)), rand64()};
      op.bh = {16'($urandom_range(0, 65535)), rand64()};
      op.bl = {16'($urandom_range(0, 65535)), rand64()};
      return op;
    end
    case ($urandom_range(0, 7))
      0: hc = $urandom_range(1, 32766);
      1: hc = $urandom_range(1, 90);        // results near underflow
      2: hc = $urandom_range(32700, 32766); // results near overflow
      default: hc = $urandom_range(BIAS_V - 200, BIAS_V + 200);
    endcase
    op.ah = rand_word(hc);
    op.al = rand_word(hc - 64 - $urandom_range(0, 10));
    if ($urandom_range(0, 7) == 0) begin
      // near cancellation of the high words
      op.bh = op.ah;
      op.bh.se[15] = ~op.ah.se[15];
      op.bh.sig[7:0] = 8'($urandom);
      op.bl = rand_word(hc - 64 - $urandom_range(0, 70));
    end else begin
      op.bh = rand_word(hc + $urandom_range(0, 4) - 2);
      op.bl = rand_word(hc - 64 - $urandom_range(0, 10));
    end
    return op;
  endfunction

  task automatic add_row(xf_t ah, xf_t al, xf_t bh, xf_t bl, bit typed = 1'b0,
                         xf_t wh = '0, xf_t wl = '0);
    table_row_t row;
    row.op.ah = ah;
    row.op.al = al;
    row.op.bh = bh;
    row.op.bl = bl;
    row.typed = typed;
    row.want.hi = wh;
    row.want.lo = wl;
    directed_rows.push_back(row);
  endtask

  // drive one operand transfer; returns after the accepting edge
  task automatic drive_item(dd_operands_t op, dd_sum_t want, int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    {a_high_sign_exp_i, a_high_significand_i} <= op.ah;
    {a_low_sign_exp_i, a_low_significand_i}   <= op.al;
    {b_high_sign_exp_i, b_high_significand_i} <= op.bh;
    {b_low_sign_exp_i, b_low_significand_i}   <= op.bl;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    expected_sums.push_back(want);
    @(posedge clk_i);
  endtask

  // ---------------- result check, sampled mid-cycle
  always @(negedge clk_i) begin
    dd_sum_t w;
    if (rst_ni && done_o) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sum transfer: %h %h %h %h",
          sum_high_sign_exp_o, sum_high_significand_o, sum_low_sign_exp_o,
          sum_low_significand_o);
      end else begin
        w = expected_sums.pop_front();
        if (w.hi.se !== sum_high_sign_exp_o || w.hi.sig !== sum_high_significand_o ||
            w.lo.se !== sum_low_sign_exp_o || w.lo.sig !== sum_low_significand_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sum mismatch: high exp %h_%h got %h_%h", w.hi.se, w.hi.sig,
                     sum_high_sign_exp_o, sum_high_significand_o);
            $display("              low  exp %h_%h got %h_%h", w.lo.se, w.lo.sig,
                     sum_low_sign_exp_o, sum_low_significand_o);
          end
        end
      end
    end
  end

  // watchdog: cycles with neither an operand nor a sum transfer
  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    xf_t one, zero, nzero, maxf, pinf, ninf, bad, dnan, snan, pden, tiny, allones;
    dd_operands_t op;
    dd_sum_t want;
    bit no_gaps;
    one     = mk_xf(1'b0, 15'd16383, INT_BIT);
    zero    = mk_xf(1'b0, '0, '0);
    nzero   = mk_xf(1'b1, '0, '0);
    maxf    = mk_xf(1'b0, 15'd32766, '1);
    pinf    = mk_xf(1'b0, EXP_ONES, INT_BIT);
    ninf    = mk_xf(1'b1, EXP_ONES, INT_BIT);
    bad     = mk_xf(1'b0, 15'd1234, 64'h0123_4567_89AB_CDEF);
    dnan    = default_nan();
    snan    = mk_xf(1'b0, EXP_ONES, INT_BIT | 64'h5);
    pden    = mk_xf(1'b0, '0, INT_BIT | 64'h3);
    tiny    = mk_xf(1'b0, '0, 64'd1);
    allones = {16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF};

    add_row(zero, zero, zero, zero, 1'b1, zero, zero);
    add_row(bad, zero, one, zero, 1'b1, dnan, dnan);
    add_row(pinf, zero, ninf, zero, 1'b1, dnan, dnan);
    add_row(one, zero, one, mk_xf(1'b0, EXP_ONES, 64'h1), 1'b1, dnan, dnan);
    add_row(nzero, nzero, nzero, nzero);
    add_row(one, zero, one, zero);
    add_row(maxf, zero, maxf, zero);
    add_row(maxf, mk_xf(1'b0, 15'd32700, '1), one, zero);
    add_row(snan, zero, one, zero);
    add_row(snan, one, mk_xf(1'b1, EXP_ONES, INT_BIT | 64'h9), one);
    add_row(pden, tiny, pden, tiny);
    add_row(tiny, tiny, mk_xf(1'b1, '0, 64'h7FFF_FFFF_FFFF_FFFF), tiny);
    add_row(one, mk_xf(1'b0, 15'd16313, INT_BIT), mk_xf(1'b1, 15'd16383, INT_BIT), zero);
    add_row(one, mk_xf(1'b0, 15'd16300, '1), mk_xf(1'b0, 15'd16320, '1),
            mk_xf(1'b1, 15'd16250, INT_BIT | 64'h1));
    add_row(mk_xf(1'b0, 15'd30000, INT_BIT), one, mk_xf(1'b1, 15'd2, '1), one);
    add_row(pinf, one, one, snan);
    add_row(allones, allones, allones, allones);
    add_row(mk_xf(1'b1, 15'd1, INT_BIT), tiny, mk_xf(1'b0, 15'd1, INT_BIT | 64'd1), zero);
    add_row(mk_xf(1'b0, EXP_ONES, '0), zero, zero, zero);
    add_row(mk_xf(1'b0, 15'd16383, '1), mk_xf(1'b0, 15'd16319, '1), one, one);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : accurate_dd_sum(directed_rows[i].op);
      drive_item(directed_rows[i].op, want, $urandom_range(0, 8));
    end

    no_gaps = 1'b0;
    for (int n = 0; n < 1250; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      op = rand_operands();
      drive_item(op, accurate_dd_sum(op), no_gaps ? 0 : $urandom_range(0, 8));
    end
    start <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
